FILE: sv/mtx_pkg.sv
// Package for the generation-tagged mutex table.
// Holds sizes, operation/status codes, controller states and row types.
// No dependencies.
package mtx_pkg;

    localparam int POOL_DEPTH  = 64;
    localparam int QUEUE_DEPTH = 8;
    localparam int INDEX_BITS  = 6;
    localparam int TASK_W      = 8;
    localparam int HANDLE_W    = 32;
    localparam int GEN_W       = HANDLE_W - 1 - INDEX_BITS;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int IN_W        = 48;
    localparam int OUT_W       = 48;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_LOCK    = 3'd2,
        OP_TRYLOCK = 3'd3,
        OP_UNLOCK  = 3'd4,
        OP_DETACH  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_INVALID   = 3'd1,
        ST_BUSY      = 3'd2,
        ST_QUEUED    = 3'd3,
        ST_QFULL     = 3'd4,
        ST_POOL_FULL = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic              locked;
        logic [TASK_W-1:0] owner;
        logic [CNT_W-1:0]  count;
    } slot_t;

    typedef logic [QUEUE_DEPTH-1:0][TASK_W-1:0] wrow_t;

endpackage

FILE: sv/mtx_slot_mem.sv
// Slot state memory: generation, lock, owner and waiter count per slot.
// Per-entry valid bits make unwritten entries read as zero. Uses mtx_pkg.
module mtx_slot_mem
    import mtx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [INDEX_BITS-1:0] addr,
    input  logic                  we,
    input  slot_t                 wdata,
    output slot_t                 rdata
);

    slot_t                  mem [POOL_DEPTH];
    slot_t                  rd_reg;
    logic                   rd_valid_reg;
    logic [POOL_DEPTH-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[addr];
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

FILE: sv/mtx_wait_mem.sv
// Waiter queue memory: one row of QUEUE_DEPTH task ids per slot.
// Only entries below the slot's count are meaningful. Uses mtx_pkg.
module mtx_wait_mem
    import mtx_pkg::*;
(
    input  logic                  clk,
    input  logic [INDEX_BITS-1:0] addr,
    input  logic                  we,
    input  wrow_t                 wdata,
    output wrow_t                 rdata
);

    wrow_t mem [POOL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/mutex_table_with_fifo_handoff.sv
// Top level of the generation-tagged mutex table with FIFO hand-off.
// Depends on mtx_pkg, mtx_slot_mem and mtx_wait_mem.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: operation, handle, task_req
// m_*      out  m_tvalid/m_tready  tdata: status, new_handle, wake_valid, woken_id; tlast
//
// Each non-detach transaction steps through accept, memory read and execute.
// Detach walks every slot, a memory read and an execute step per slot through the single
// memory port, then ends with a flush step.
// Reset clears the in-use vector, the slot memory valid bits and the controller.
// A full output register stalls an emitting execute step; the memories are re-read at a
// stable address, so nothing is lost. Input is taken only when the controller idles.
module mutex_table_with_fifo_handoff
    import mtx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [2:0] operation, [34:3] handle, [42:35] task_req
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [2:0] status, [33:3] new_handle, [34] wake_valid,
                                        // [42:35] woken_id
    output logic             m_tlast
);

    state_t                state_reg, state_next;
    logic [2:0]            op_reg, op_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [TASK_W-1:0]     task_reg, task_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  full_reg, full_next;   // alloc found no free slot
    logic [POOL_DEPTH-1:0] used_reg, used_next;
    logic                  pend_reg, pend_next;   // detach hand-off held back
    logic [TASK_W-1:0]     pend_task_reg, pend_task_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    slot_t                 slot_rd, slot_wr;
    wrow_t                 wrow_rd, wrow_wr;
    logic                  slot_we, wait_we;

    logic                  in_fire, can_load;
    logic                  exec_fire, need_load, scan_end;
    logic [INDEX_BITS-1:0] free_idx;
    logic                  any_free;

    // Decoded handle and the result of the current execute step.
    logic                  h_ok;
    logic [GEN_W-1:0]      h_gen;
    logic [2:0]            res_status;
    logic [HANDLE_W-2:0]   res_handle;
    logic                  res_wake;
    logic [TASK_W-1:0]     res_task;
    logic                  res_last;
    logic [GEN_W-1:0]      gen_inc;
    wrow_t                 comp_row, pop_row;
    logic [CNT_W-1:0]      comp_cnt;
    logic                  det_hand;

    mtx_slot_mem u_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (idx_reg),
        .we    (slot_we),
        .wdata (slot_wr),
        .rdata (slot_rd)
    );

    mtx_wait_mem u_wait (
        .clk   (clk),
        .addr  (idx_reg),
        .we    (wait_we),
        .wdata (wrow_wr),
        .rdata (wrow_rd)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign can_load = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign scan_end = (idx_reg == INDEX_BITS'(POOL_DEPTH - 1));

    // Lowest free slot for alloc.
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = INDEX_BITS'(i);
                any_free = 1'b1;
            end
        end
    end

    // Handle check against the slot just read.
    assign h_gen = handle_reg[HANDLE_W-2:INDEX_BITS];
    assign h_ok  = !handle_reg[HANDLE_W-1]
                && ({1'b0, idx_reg} < (INDEX_BITS + 1)'(POOL_DEPTH))
                && (h_gen != '0)
                && used_reg[idx_reg]
                && (slot_rd.gen == h_gen);

    assign gen_inc = (slot_rd.gen == {GEN_W{1'b1}}) ? GEN_W'(1) : slot_rd.gen + GEN_W'(1);

    // Drop the detached task from the queue, keeping order.
    always_comb
    begin
        logic [CNT_W-1:0] j;
        j        = '0;
        comp_row = wrow_rd;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if ((CNT_W'(i) < slot_rd.count) && (wrow_rd[i] != task_reg))
            begin
                comp_row[j[QIDX_W-1:0]] = wrow_rd[i];
                j = j + CNT_W'(1);
            end
        end
        comp_cnt = j;
    end

    // Pop the head of the (compacted for detach) row.
    always_comb
    begin
        wrow_t src;
        src = (op_reg == OP_DETACH) ? comp_row : wrow_rd;
        pop_row = src;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            pop_row[i] = src[i + 1];
        end
    end

    assign det_hand = used_reg[idx_reg] && slot_rd.locked && (slot_rd.owner == task_reg)
                   && (comp_cnt != '0);

    // Execute step: result fields and memory write-back.
    always_comb
    begin
        res_status = ST_DONE;
        res_handle = '0;
        res_wake   = 1'b0;
        res_task   = '0;
        res_last   = 1'b1;
        slot_wr    = slot_rd;
        wrow_wr    = wrow_rd;
        slot_we    = 1'b0;
        wait_we    = 1'b0;
        used_next  = used_reg;
        need_load  = 1'b1;
        case (op_reg)
            OP_ALLOC:
            begin
                if (full_reg)
                begin
                    res_status = ST_POOL_FULL;
                end
                else
                begin
                    slot_wr    = '{gen: gen_inc, locked: 1'b0, owner: '0, count: '0};
                    slot_we    = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    res_handle = {gen_inc, idx_reg};
                end
            end
            OP_FREE:
            begin
                if (!h_ok)
                begin
                    res_status = ST_INVALID;
                end
                else if (slot_rd.locked || (slot_rd.count != '0))
                begin
                    res_status = ST_BUSY;
                end
                else
                begin
                    used_next[idx_reg] = 1'b0;
                end
            end
            OP_LOCK, OP_TRYLOCK:
            begin
                if (!h_ok)
                begin
                    res_status = ST_INVALID;
                end
                else if (!slot_rd.locked)
                begin
                    slot_wr.locked = 1'b1;
                    slot_wr.owner  = task_reg;
                    slot_we        = 1'b1;
                end
                else if (op_reg == OP_TRYLOCK)
                begin
                    res_status = ST_BUSY;
                end
                else if (slot_rd.count >= CNT_W'(QUEUE_DEPTH))
                begin
                    res_status = ST_QFULL;
                end
                else
                begin
                    wrow_wr[slot_rd.count[QIDX_W-1:0]] = task_reg;
                    wait_we       = 1'b1;
                    slot_wr.count = slot_rd.count + CNT_W'(1);
                    slot_we       = 1'b1;
                    res_status    = ST_QUEUED;
                end
            end
            OP_UNLOCK:
            begin
                if (!h_ok)
                begin
                    res_status = ST_INVALID;
                end
                else if (slot_rd.count == '0)
                begin
                    slot_wr.locked = 1'b0;
                    slot_wr.owner  = '0;
                    slot_we        = 1'b1;
                end
                else
                begin
                    wrow_wr        = pop_row;
                    wait_we        = 1'b1;
                    slot_wr.locked = 1'b1;
                    slot_wr.owner  = wrow_rd[0];
                    slot_wr.count  = slot_rd.count - CNT_W'(1);
                    slot_we        = 1'b1;
                    res_wake       = 1'b1;
                    res_task       = wrow_rd[0];
                end
            end
            OP_DETACH:
            begin
                // Emit the held hand-off only when a newer one replaces it.
                need_load  = det_hand && pend_reg;
                res_wake   = 1'b1;
                res_task   = pend_task_reg;
                res_last   = 1'b0;
                if (used_reg[idx_reg])
                begin
                    wait_we       = 1'b1;
                    slot_we       = 1'b1;
                    wrow_wr       = comp_row;
                    slot_wr.count = comp_cnt;
                    if (slot_rd.locked && (slot_rd.owner == task_reg))
                    begin
                        if (comp_cnt == '0)
                        begin
                            slot_wr.locked = 1'b0;
                            slot_wr.owner  = '0;
                        end
                        else
                        begin
                            wrow_wr       = pop_row;
                            slot_wr.owner = comp_row[0];
                            slot_wr.count = comp_cnt - CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                res_status = ST_INVALID;
            end
        endcase
        exec_fire = (state_reg == S_EXEC) && (!need_load || can_load);
        if (!exec_fire)
        begin
            slot_we   = 1'b0;
            wait_we   = 1'b0;
            used_next = used_reg;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    if (op_reg != OP_DETACH)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (scan_end)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Register updates driven by the current state.
    always_comb
    begin
        op_next        = op_reg;
        handle_next    = handle_reg;
        task_next      = task_reg;
        idx_next       = idx_reg;
        full_next      = full_reg;
        pend_next      = pend_reg;
        pend_task_next = pend_task_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = s_tdata[2:0];
                    handle_next = s_tdata[34:3];
                    task_next   = s_tdata[42:35];
                    full_next   = !any_free;
                    pend_next   = 1'b0;
                    if (s_tdata[2:0] == OP_ALLOC)
                    begin
                        idx_next = free_idx;
                    end
                    else if (s_tdata[2:0] == OP_DETACH)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = s_tdata[3 +: INDEX_BITS];
                    end
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    if (need_load)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {5'd0, res_task, res_wake, res_handle, res_status};
                        out_last_next  = res_last;
                    end
                    if (op_reg == OP_DETACH)
                    begin
                        idx_next = idx_reg + INDEX_BITS'(1);
                        if (det_hand)
                        begin
                            pend_next      = 1'b1;
                            pend_task_next = comp_row[0];
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'd0, (pend_reg ? pend_task_reg : TASK_W'(0)),
                                      pend_reg, (HANDLE_W - 1)'(0), ST_DONE};
                    out_last_next  = 1'b1;
                    pend_next      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        handle_reg    <= handle_next;
        task_reg      <= task_next;
        idx_reg       <= idx_next;
        full_reg      <= full_next;
        pend_task_reg <= pend_task_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    // Memory writes happen only in the execute step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (slot_we || wait_we) |-> (state_reg == S_EXEC))
        else $error("memory write outside execute");

    // A held hand-off exists only while a detach runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (state_reg != S_IDLE)) |-> (op_reg == OP_DETACH))
        else $error("pending hand-off outside detach");

    // Every accepted transaction is followed by a memory read cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_READ))
        else $error("accept not followed by read");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mutex_table_with_fifo_handoff: drives random and directed
// mutex table transactions and checks each output transaction against a local model.
// Depends on mtx_pkg and the mutex_table_with_fifo_handoff RTL.

class mutex_scoreboard;
    typedef struct {
        logic [2:0]  status;
        logic [30:0] new_handle;
        logic        wake_valid;
        logic [7:0]  woken_id;
        logic        last;
    } mtx_result_t;

    bit              used    [64];
    logic [24:0]     gen     [64];
    bit              locked  [64];
    logic [7:0]      owner   [64];
    logic [7:0]      waiters [64][$];
    mtx_result_t     pending [$];
    int              errors;
    int              checked;
    int              wakes;

    function new();
        foreach (used[i])
        begin
            used[i] = 0; gen[i] = '0; locked[i] = 0; owner[i] = '0;
        end
        errors = 0; checked = 0; wakes = 0;
    endfunction

    function void push(logic [2:0] st, logic [30:0] h, int wv, logic [7:0] wt, int l);
        mtx_result_t r;
        r.status = st; r.new_handle = h; r.wake_valid = wv[0]; r.woken_id = wt;
        r.last = l[0];
        pending.push_back(r);
    endfunction

    function int decode(logic [31:0] h);
        logic [5:0]  idx;
        logic [25:0] g;
        idx = h[5:0];
        g   = h[31:6];
        if (h[31] || g == 0) return -1;
        if (!used[idx] || {1'b0, gen[idx]} != g) return -1;
        return int'(idx);
    endfunction

    // Release slot s or pass it to the head waiter; return 1 on hand-off.
    function bit release_slot(int s, output logic [7:0] woken);
        woken = '0;
        if (waiters[s].size() == 0)
        begin
            locked[s] = 0; owner[s] = '0;
            return 0;
        end
        woken = waiters[s].pop_front();
        owner[s] = woken; locked[s] = 1;
        return 1;
    endfunction

    // Note an accepted input transaction and queue the results it causes.
    function void note_input(logic [2:0] op, logic [31:0] h, logic [7:0] tsk);
        int          s;
        int          n;
        logic [7:0]  w;
        logic [24:0] g;
        case (op)
            mtx_pkg::OP_ALLOC:
            begin
                for (s = 0; s < 64; s++)
                    if (!used[s]) break;
                if (s == 64)
                    push(mtx_pkg::ST_POOL_FULL, '0, 0, '0, 1);
                else
                begin
                    g = gen[s] + 25'd1;
                    if (g == 0) g = 25'd1;
                    gen[s] = g; used[s] = 1; locked[s] = 0; owner[s] = '0;
                    waiters[s].delete();
                    push(mtx_pkg::ST_DONE, {g, s[5:0]}, 0, '0, 1);
                end
            end
            mtx_pkg::OP_FREE:
            begin
                s = decode(h);
                if (s < 0) push(mtx_pkg::ST_INVALID, '0, 0, '0, 1);
                else if (locked[s] || waiters[s].size() != 0)
                    push(mtx_pkg::ST_BUSY, '0, 0, '0, 1);
                else
                begin
                    used[s] = 0;
                    push(mtx_pkg::ST_DONE, '0, 0, '0, 1);
                end
            end
            mtx_pkg::OP_LOCK, mtx_pkg::OP_TRYLOCK:
            begin
                s = decode(h);
                if (s < 0) push(mtx_pkg::ST_INVALID, '0, 0, '0, 1);
                else if (!locked[s])
                begin
                    locked[s] = 1; owner[s] = tsk;
                    push(mtx_pkg::ST_DONE, '0, 0, '0, 1);
                end
                else if (op == mtx_pkg::OP_TRYLOCK) push(mtx_pkg::ST_BUSY, '0, 0, '0, 1);
                else if (waiters[s].size() >= 8) push(mtx_pkg::ST_QFULL, '0, 0, '0, 1);
                else
                begin
                    waiters[s].push_back(tsk);
                    push(mtx_pkg::ST_QUEUED, '0, 0, '0, 1);
                end
            end
            mtx_pkg::OP_UNLOCK:
            begin
                s = decode(h);
                if (s < 0) push(mtx_pkg::ST_INVALID, '0, 0, '0, 1);
                else if (release_slot(s, w))
                begin
                    push(mtx_pkg::ST_DONE, '0, 1, w, 1);
                    wakes++;
                end
                else push(mtx_pkg::ST_DONE, '0, 0, '0, 1);
            end
            mtx_pkg::OP_DETACH:
            begin
                n = 0;
                for (s = 0; s < 64; s++)
                begin
                    if (!used[s]) continue;
                    for (int i = waiters[s].size() - 1; i >= 0; i--)
                        if (waiters[s][i] == tsk) waiters[s].delete(i);
                    if (locked[s] && owner[s] == tsk && release_slot(s, w))
                    begin
                        push(mtx_pkg::ST_DONE, '0, 1, w, 0);
                        n++; wakes++;
                    end
                end
                if (n == 0) push(mtx_pkg::ST_DONE, '0, 0, '0, 1);
                else pending[$].last = 1;
            end
            default: push(mtx_pkg::ST_INVALID, '0, 0, '0, 1);
        endcase
    endfunction

    // Compare one output transaction with the oldest expectation.
    function void check_result(logic [47:0] d, logic l);
        mtx_result_t e;
        checked++;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result expected none actual %h last %b", $time, d, l);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[2:0] !== e.status || d[33:3] !== e.new_handle || d[34] !== e.wake_valid ||
            d[42:35] !== e.woken_id || l !== e.last)
        begin
            $display("%0t: mismatch expected st %0d h %h wv %b wt %h last %b",
                     $time, e.status, e.new_handle, e.wake_valid, e.woken_id, e.last);
            $display("%0t:          actual   st %0d h %h wv %b wt %h last %b",
                     $time, d[2:0], d[33:3], d[34], d[42:35], l);
            errors++;
        end
    endfunction
endclass

module tb;
    import mtx_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    mutex_scoreboard lock_book;
    int          send_idle;     // percent of cycles the sender idles
    int          recv_idle;     // percent of cycles the receiver stalls
    bit          hold_off;      // long receiver stall request
    int          cycles;
    int          sent;
    logic [31:0] live [$];      // handles returned by alloc

    mutex_table_with_fifo_handoff u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus a long counted hold-off on request.
    initial
    begin
        int held;
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 0;
                for (held = 0; held < 300; held++) @(posedge clk);
                hold_off = 0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Check every output transaction at the edge it is accepted.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            lock_book.check_result(m_tdata, m_tlast);

    // Watchdog on total cycles.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 1500000)
            begin
                $display("mutex_table_with_fifo_handoff verification failed");
                $finish;
            end
        end
    end

    // Offer one transaction, idle at random first, and hold until accepted.
    // Valid stays high after the accept; drain() or an idle turn of the next call drops it.
    task automatic send_op(logic [2:0] op, logic [31:0] h, logic [7:0] tsk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {5'b0, tsk, h, op};
        do @(posedge clk); while (!s_tready);
        lock_book.note_input(op, h, tsk);
        if (op == OP_ALLOC && lock_book.pending[$].status == ST_DONE)
            live.push_back({1'b0, lock_book.pending[$].new_handle});
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (lock_book.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_handle();
        logic [31:0] h;
        int r;
        r = $urandom_range(99);
        if (live.size() != 0 && r < 85) return live[$urandom_range(live.size() - 1)];
        h = $urandom;
        if (r < 92 && live.size() != 0)   // stale generation on a live index
        begin
            h = live[$urandom_range(live.size() - 1)];
            h[31:6] = h[31:6] + 26'd1;
        end
        return h;
    endfunction

    task automatic random_op();
        int          r;
        logic [2:0]  op;
        r = $urandom_range(99);
        if (r < 12) op = OP_ALLOC;
        else if (r < 20) op = OP_FREE;
        else if (r < 50) op = OP_LOCK;
        else if (r < 60) op = OP_TRYLOCK;
        else if (r < 85) op = OP_UNLOCK;
        else if (r < 95) op = OP_DETACH;
        else op = 3'($urandom_range(7));
        // Small task pool keeps owners and waiters colliding.
        send_op(op, pick_handle(), (r % 3 == 0) ? 8'($urandom) : 8'($urandom_range(7)));
    endtask

    initial
    begin
        logic [31:0] h0;
        lock_book = new();
        rst_n = 0; s_tvalid = 0; s_tdata = '0; hold_off = 0;
        send_idle = 0; recv_idle = 0; sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: invalid handles, lock queueing up to full, hand-off, detach.
        send_op(OP_FREE, 32'h8000_0000, 8'h00);
        send_op(OP_LOCK, 32'hffff_ffff, 8'hff);
        send_op(OP_UNLOCK, 32'h0000_0000, 8'h00);
        send_op(OP_ALLOC, '0, '0);
        h0 = live[0];
        send_op(OP_LOCK, {1'b0, h0[30:6] + 25'd1, h0[5:0]}, 8'h01);
        send_op(OP_LOCK, h0, 8'hff);
        for (int i = 0; i < 9; i++) send_op(OP_LOCK, h0, (i < 2) ? 8'hff : i[7:0]);
        send_op(OP_TRYLOCK, h0, 8'h55);
        send_op(OP_FREE, h0, 8'h00);
        send_op(OP_UNLOCK, h0, 8'h00);
        send_op(OP_DETACH, '0, 8'hff);
        send_op(OP_DETACH, '0, 8'haa);
        send_op(3'd6, h0, 8'h00);
        send_op(3'd7, 32'h7fff_ffff, 8'h00);
        drain();

        // Fill the pool, then alloc once more for the pool-full case.
        for (int i = 0; i < 64; i++) send_op(OP_ALLOC, '0, '0);
        drain();
        // Stall the receiver for a long stretch while items keep coming.
        hold_off = 1;
        for (int i = 0; i < 40; i++)
            send_op(OP_LOCK, live[i % 4], i[7:0]);
        drain();

        send_idle = 19; recv_idle = 77;
        for (int i = 0; i < 140; i++) random_op();
        drain();
        send_idle = 77; recv_idle = 19;
        for (int i = 0; i < 70; i++) random_op();
        send_idle = 0; recv_idle = 0;
        for (int i = 0; i < 70; i++) random_op();
        drain();
        repeat (200) @(posedge clk);

        $display("Covered %0d input transactions, %0d results checked, %0d wake hand-offs.",
                 sent, lock_book.checked, lock_book.wakes);
        if (lock_book.errors == 0 && lock_book.pending.size() == 0)
            $display("mutex_table_with_fifo_handoff verification clean");
        else
            $display("mutex_table_with_fifo_handoff verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
sv/mtx_pkg.sv
sv/mtx_slot_mem.sv
sv/mtx_wait_mem.sv
sv/mutex_table_with_fifo_handoff.sv
bench/tb.sv
